[design/lcdsc_pkg.sv]
// Shared types and constants for the LCD scanline status controller.
package lcdsc_pkg;

   // Scanline event codes.
   localparam logic [1:0] ACT_LINE_END  = 2'd0;
   localparam logic [1:0] ACT_OAM_START = 2'd1;
   localparam logic [1:0] ACT_XFER_START = 2'd2;
   localparam logic [1:0] ACT_HDMA_LOAD = 2'd3;

   // LCD mode codes.
   localparam logic [1:0] MODE_HBLANK = 2'd0;
   localparam logic [1:0] MODE_VBLANK = 2'd1;
   localparam logic [1:0] MODE_OAM    = 2'd2;
   localparam logic [1:0] MODE_XFER   = 2'd3;

   // Status interrupt enable bit positions.
   localparam int STAT_EN_HBLANK = 0;
   localparam int STAT_EN_VBLANK = 1;
   localparam int STAT_EN_OAM    = 2;
   localparam int STAT_EN_LYC    = 3;

   // Configuration register indexes.
   localparam logic [2:0] CSR_LCD_ENABLE  = 3'd0;
   localparam logic [2:0] CSR_LYC_VALUE   = 3'd1;
   localparam logic [2:0] CSR_STAT_MASK   = 3'd2;
   localparam logic [2:0] CSR_COLOR_MODE  = 3'd3;
   localparam logic [2:0] CSR_HDMA_HBLANK = 3'd4;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 8;

   // HDMA address shaping.
   localparam logic [15:0] HDMA_SRC_MASK  = 16'hfff0;
   localparam logic [15:0] HDMA_DEST_MASK = 16'h1ff0;
   localparam logic [15:0] HDMA_VRAM_BASE = 16'h8000;
   localparam logic [15:0] HDMA_BLOCK_BYTES = 16'd16;

   typedef struct packed {
      logic       lcd_enable;
      logic [7:0] lyc_value;
      logic [3:0] stat_irq_mask;
      logic       color_mode;
      logic       hdma_hblank_mode;
   } cfg_type;

   typedef struct packed {
      logic [7:0]  line_count;
      logic [1:0]  mode_bits;
      logic        match_flag;
      logic [15:0] frame_counter;
      logic [15:0] dma_source_addr;
      logic [15:0] dma_dest_addr;
      logic [7:0]  dma_blocks_left;
      logic        dma_idle;
   } state_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [15:0] load_source;
      logic [15:0] load_dest;
      logic [7:0]  load_blocks;
   } req_type;

   typedef struct packed {
      logic [7:0]  current_line;
      logic [1:0]  lcd_mode;
      logic        lyc_match;
      logic        vblank_irq;
      logic        stat_irq;
      logic        render_request;
      logic        block_valid;
      logic [15:0] block_source;
      logic [15:0] block_dest;
      logic        dma_finished;
      logic [15:0] frames_done;
   } rsp_type;

endpackage

[design/lcd_scanline_status_controller.sv]
// Top level of the LCD scanline status controller.
// A transaction accepted into the input register moves on into the result register, where
// rsp_valid rises, once the result register is free.
// Throughput: one transaction per cycle unless the result channel stalls; the single
// state update between input and result register sets that figure.
// Reset: synchronous, active high; empties both registers, loads default settings and state.
module lcd_scanline_status_controller #(
   parameter int LINES_PER_FRAME = 154,
   parameter int VISIBLE_LINES   = 144
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // Configuration write port.
   input  logic                                  csr_write,
   input  logic [lcdsc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [lcdsc_pkg::CSR_DATA_W-1:0]      csr_wdata,
   // Event channel.
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [1:0]                            req_action,
   input  logic [15:0]                           req_load_source,
   input  logic [15:0]                           req_load_dest,
   input  logic [7:0]                            req_load_blocks,
   // Result channel.
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [7:0]                            rsp_current_line,
   output logic [1:0]                            rsp_lcd_mode,
   output logic                                  rsp_lyc_match,
   output logic                                  rsp_vblank_irq,
   output logic                                  rsp_stat_irq,
   output logic                                  rsp_render_request,
   output logic                                  rsp_block_valid,
   output logic [15:0]                           rsp_block_source,
   output logic [15:0]                           rsp_block_dest,
   output logic                                  rsp_dma_finished,
   output logic [15:0]                           rsp_frames_done
);
   import lcdsc_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   state_type state_ff, state_in;
   req_type   req_ff;
   rsp_type   rsp_ff, rsp_in;
   logic      req_valid_ff, req_valid_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      advance;
   logic      req_take;

   // Configuration register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_LCD_ENABLE:  cfg_in.lcd_enable       = csr_wdata[0];
            CSR_LYC_VALUE:   cfg_in.lyc_value        = csr_wdata[7:0];
            CSR_STAT_MASK:   cfg_in.stat_irq_mask    = csr_wdata[3:0];
            CSR_COLOR_MODE:  cfg_in.color_mode       = csr_wdata[0];
            CSR_HDMA_HBLANK: cfg_in.hdma_hblank_mode = csr_wdata[0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   // Handshake: the input register moves on whenever the result register is free.
   assign advance      = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall    = req_valid_ff && !advance;
   assign req_take     = req_valid && !req_stall;
   assign req_valid_in = req_take || (req_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   lcdsc_step #(
      .LINES_PER_FRAME(LINES_PER_FRAME),
      .VISIBLE_LINES  (VISIBLE_LINES)
   ) u_step (
      .cfg(cfg_ff),
      .cur(state_ff),
      .req(req_ff),
      .nxt(state_in),
      .rsp(rsp_in)
   );

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '{lcd_enable: 1'b1, lyc_value: 8'd0, stat_irq_mask: 4'd0,
                           color_mode: 1'b0, hdma_hblank_mode: 1'b0};
         state_ff     <= '{line_count: 8'd0, mode_bits: MODE_VBLANK, match_flag: 1'b1,
                           frame_counter: 16'd0, dma_source_addr: 16'd0,
                           dma_dest_addr: 16'd0, dma_blocks_left: 8'd0,
                           dma_idle: 1'b1};
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff <= '{action: req_action, load_source: req_load_source,
                     load_dest: req_load_dest, load_blocks: req_load_blocks};
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_current_line   = rsp_ff.current_line;
   assign rsp_lcd_mode       = rsp_ff.lcd_mode;
   assign rsp_lyc_match      = rsp_ff.lyc_match;
   assign rsp_vblank_irq     = rsp_ff.vblank_irq;
   assign rsp_stat_irq       = rsp_ff.stat_irq;
   assign rsp_render_request = rsp_ff.render_request;
   assign rsp_block_valid    = rsp_ff.block_valid;
   assign rsp_block_source   = rsp_ff.block_source;
   assign rsp_block_dest     = rsp_ff.block_dest;
   assign rsp_dma_finished   = rsp_ff.dma_finished;
   assign rsp_frames_done    = rsp_ff.frames_done;

endmodule

[design/lcdsc_step.sv]
// Next-state and result logic for one scanline event transaction.
module lcdsc_step #(
   parameter int LINES_PER_FRAME = 154,
   parameter int VISIBLE_LINES   = 144
) (
   input  lcdsc_pkg::cfg_type   cfg,
   input  lcdsc_pkg::state_type cur,
   input  lcdsc_pkg::req_type   req,
   output lcdsc_pkg::state_type nxt,
   output lcdsc_pkg::rsp_type   rsp
);
   import lcdsc_pkg::*;

   localparam logic [8:0] LinesPerFrameW = 9'(LINES_PER_FRAME);
   localparam logic [7:0] VisibleLinesW  = 8'(VISIBLE_LINES);

   logic [8:0] line_inc;
   logic       line_wrap;
   logic [7:0] line_new;
   logic [7:0] blocks_dec;
   logic       hdma_go;

   // Line advance with wrap at the end of the frame.
   assign line_inc   = {1'b0, cur.line_count} + 9'd1;
   assign line_wrap  = (line_inc >= LinesPerFrameW);
   assign line_new   = line_wrap ? 8'(line_inc - LinesPerFrameW) : line_inc[7:0];
   assign blocks_dec = cur.dma_blocks_left - 8'd1;
   assign hdma_go    = cfg.color_mode && !cur.dma_idle && cfg.hdma_hblank_mode;

   always_comb begin
      nxt = cur;
      rsp = '0;
      if (cfg.lcd_enable) begin
         case (req.action)
            ACT_LINE_END: begin
               nxt.line_count = line_new;
               if (line_wrap) begin
                  nxt.frame_counter = cur.frame_counter + 16'd1;
               end
               // Line compare match.
               nxt.match_flag = (line_new == cfg.lyc_value);
               if (nxt.match_flag && cfg.stat_irq_mask[STAT_EN_LYC]) begin
                  rsp.stat_irq = 1'b1;
               end
               if (line_new == VisibleLinesW) begin
                  nxt.mode_bits  = MODE_VBLANK;
                  rsp.vblank_irq = 1'b1;
                  if (cfg.stat_irq_mask[STAT_EN_VBLANK]) begin
                     rsp.stat_irq = 1'b1;
                  end
               end else if (line_new < VisibleLinesW) begin
                  nxt.mode_bits = MODE_HBLANK;
                  // One HDMA block per visible-line HBLANK.
                  if (hdma_go) begin
                     rsp.block_valid     = 1'b1;
                     rsp.block_source    = cur.dma_source_addr & HDMA_SRC_MASK;
                     rsp.block_dest      = (cur.dma_dest_addr & HDMA_DEST_MASK)
                                           | HDMA_VRAM_BASE;
                     nxt.dma_source_addr = cur.dma_source_addr + HDMA_BLOCK_BYTES;
                     nxt.dma_dest_addr   = cur.dma_dest_addr + HDMA_BLOCK_BYTES;
                     nxt.dma_blocks_left = blocks_dec;
                     if (blocks_dec == 8'd0) begin
                        nxt.dma_idle     = 1'b1;
                        rsp.dma_finished = 1'b1;
                     end
                  end
                  if (cfg.stat_irq_mask[STAT_EN_HBLANK]) begin
                     rsp.stat_irq = 1'b1;
                  end
               end
            end
            ACT_OAM_START: begin
               nxt.mode_bits = MODE_OAM;
               if (cfg.stat_irq_mask[STAT_EN_OAM]) begin
                  rsp.stat_irq = 1'b1;
               end
            end
            ACT_XFER_START: begin
               nxt.mode_bits      = MODE_XFER;
               rsp.render_request = 1'b1;
            end
            ACT_HDMA_LOAD: begin
               nxt.dma_source_addr = req.load_source;
               nxt.dma_dest_addr   = req.load_dest;
               nxt.dma_blocks_left = req.load_blocks;
               nxt.dma_idle        = (req.load_blocks == 8'd0);
            end
            default: begin
               nxt = cur;
            end
         endcase
      end
      // Visible state after the event.
      rsp.current_line = nxt.line_count;
      rsp.lcd_mode     = nxt.mode_bits;
      rsp.lyc_match    = nxt.match_flag;
      rsp.frames_done  = nxt.frame_counter;
   end

endmodule

[design/lcdsc_checker.sv]
// Port-level checker for the LCD scanline status controller, bound to the top level.
module lcdsc_checker #(
   parameter int VISIBLE_LINES = 144
) (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [7:0]  rsp_current_line,
   input logic [1:0]  rsp_lcd_mode,
   input logic        rsp_vblank_irq,
   input logic        rsp_render_request,
   input logic        rsp_block_valid,
   input logic [15:0] rsp_block_source,
   input logic [15:0] rsp_block_dest,
   input logic        rsp_dma_finished
);
   import lcdsc_pkg::*;

   // Block fields are zero when no block is requested.
   a_no_block_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_block_valid |->
         rsp_block_source == 16'd0 && rsp_block_dest == 16'd0 && !rsp_dma_finished)
      else $error("block fields nonzero without a block request");

   // A block targets video memory and only happens on an HBLANK entry.
   a_block_hblank: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_block_valid |->
         rsp_block_dest[15] && rsp_lcd_mode == MODE_HBLANK)
      else $error("block request outside HBLANK or video memory");

   // The vertical blank request comes with entry into VBLANK on the first hidden line.
   a_vblank_line: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_vblank_irq |->
         rsp_lcd_mode == MODE_VBLANK && rsp_current_line == 8'(VISIBLE_LINES))
      else $error("vblank request on wrong line or mode");

   // A render request only comes with transfer mode.
   a_render_xfer: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_render_request |-> rsp_lcd_mode == MODE_XFER)
      else $error("render request outside transfer mode");

   // A stalled result transaction holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=>
         rsp_valid && $stable(rsp_current_line) && $stable(rsp_block_dest))
      else $error("stalled result changed");

endmodule

bind lcd_scanline_status_controller lcdsc_checker #(
   .VISIBLE_LINES(VISIBLE_LINES)
) u_lcdsc_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_current_line  (rsp_current_line),
   .rsp_lcd_mode      (rsp_lcd_mode),
   .rsp_vblank_irq    (rsp_vblank_irq),
   .rsp_render_request(rsp_render_request),
   .rsp_block_valid   (rsp_block_valid),
   .rsp_block_source  (rsp_block_source),
   .rsp_block_dest    (rsp_block_dest),
   .rsp_dma_finished  (rsp_dma_finished)
);

[dv/tb_top.sv]
// Self-checking testbench for the LCD scanline status controller.
`timescale 1ns / 100ps

module tb_top;
   import lcdsc_pkg::*;

   localparam int LINES_PER_FRAME = 154;
   localparam int VISIBLE_LINES   = 144;
   localparam int RANDOM_ITEMS    = 1600;
   localparam int HOLD_CYCLES     = 80;
   localparam int CYCLE_LIMIT     = 400000;

   typedef enum bit {ROW_SETUP, ROW_EVENT} row_kind_type;

   // One line of the directed stimulus: a register setup or a scanline event.
   typedef struct {
      row_kind_type kind;
      cfg_type      cfg;
      req_type      ev;
      bit           has_lit;
      rsp_type      lit;
   } stim_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [1:0]             req_action = ACT_LINE_END;
   logic [15:0]            req_load_source = '0;
   logic [15:0]            req_load_dest = '0;
   logic [7:0]             req_load_blocks = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [7:0]             rsp_current_line;
   logic [1:0]             rsp_lcd_mode;
   logic                   rsp_lyc_match;
   logic                   rsp_vblank_irq;
   logic                   rsp_stat_irq;
   logic                   rsp_render_request;
   logic                   rsp_block_valid;
   logic [15:0]            rsp_block_source;
   logic [15:0]            rsp_block_dest;
   logic                   rsp_dma_finished;
   logic [15:0]            rsp_frames_done;

   // Predicted display state, settings and the statuses still to come.
   state_type scan_st;
   cfg_type   regs;
   rsp_type   status_due[$];

   int  error_count = 0;
   int  cycle_count = 0;
   int  events_sent = 0;
   int  results_seen = 0;
   int  vblanks_seen = 0;
   int  blocks_seen = 0;
   int  rsp_wait_left = 0;
   bit  rsp_calm = 1'b0;
   bit  send_calm = 1'b0;
   int  calm_left = 0;
   bit  hold_go = 1'b0;
   bit  hold_rsp = 1'b0;

   lcd_scanline_status_controller #(
      .LINES_PER_FRAME(LINES_PER_FRAME),
      .VISIBLE_LINES(VISIBLE_LINES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_action(req_action),
      .req_load_source(req_load_source),
      .req_load_dest(req_load_dest),
      .req_load_blocks(req_load_blocks),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_current_line(rsp_current_line),
      .rsp_lcd_mode(rsp_lcd_mode),
      .rsp_lyc_match(rsp_lyc_match),
      .rsp_vblank_irq(rsp_vblank_irq),
      .rsp_stat_irq(rsp_stat_irq),
      .rsp_render_request(rsp_render_request),
      .rsp_block_valid(rsp_block_valid),
      .rsp_block_source(rsp_block_source),
      .rsp_block_dest(rsp_block_dest),
      .rsp_dma_finished(rsp_dma_finished),
      .rsp_frames_done(rsp_frames_done)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Advance the predicted display by one event and return the status it produces.
   function automatic rsp_type advance_scanline(req_type ev);
      rsp_type     st;
      int unsigned nl;
      st = '0;
      if (regs.lcd_enable) begin
         case (ev.action)
            ACT_LINE_END: begin
               nl = scan_st.line_count + 1;
               if (nl >= LINES_PER_FRAME) begin
                  nl = nl - LINES_PER_FRAME;
                  scan_st.frame_counter = scan_st.frame_counter + 16'd1;
               end
               scan_st.line_count = nl[7:0];
               scan_st.match_flag = (nl[7:0] == regs.lyc_value);
               if (scan_st.match_flag && regs.stat_irq_mask[STAT_EN_LYC])
                  st.stat_irq = 1'b1;
               if (nl == VISIBLE_LINES) begin
                  scan_st.mode_bits = MODE_VBLANK;
                  st.vblank_irq = 1'b1;
                  if (regs.stat_irq_mask[STAT_EN_VBLANK])
                     st.stat_irq = 1'b1;
               end else if (nl < VISIBLE_LINES) begin
                  scan_st.mode_bits = MODE_HBLANK;
                  // HBLANK DMA moves one block per visible line while armed.
                  if (regs.color_mode && regs.hdma_hblank_mode && !scan_st.dma_idle) begin
                     st.block_valid = 1'b1;
                     st.block_source = scan_st.dma_source_addr & HDMA_SRC_MASK;
                     st.block_dest = (scan_st.dma_dest_addr & HDMA_DEST_MASK) | HDMA_VRAM_BASE;
                     scan_st.dma_source_addr = scan_st.dma_source_addr + HDMA_BLOCK_BYTES;
                     scan_st.dma_dest_addr = scan_st.dma_dest_addr + HDMA_BLOCK_BYTES;
                     scan_st.dma_blocks_left = scan_st.dma_blocks_left - 8'd1;
                     if (scan_st.dma_blocks_left == 8'd0) begin
                        scan_st.dma_idle = 1'b1;
                        st.dma_finished = 1'b1;
                     end
                  end
                  if (regs.stat_irq_mask[STAT_EN_HBLANK])
                     st.stat_irq = 1'b1;
               end
            end
            ACT_OAM_START: begin
               scan_st.mode_bits = MODE_OAM;
               if (regs.stat_irq_mask[STAT_EN_OAM])
                  st.stat_irq = 1'b1;
            end
            ACT_XFER_START: begin
               scan_st.mode_bits = MODE_XFER;
               st.render_request = 1'b1;
            end
            default: begin
               scan_st.dma_source_addr = ev.load_source;
               scan_st.dma_dest_addr = ev.load_dest;
               scan_st.dma_blocks_left = ev.load_blocks;
               scan_st.dma_idle = (ev.load_blocks == 8'd0);
            end
         endcase
      end
      st.current_line = scan_st.line_count;
      st.lcd_mode = scan_st.mode_bits;
      st.lyc_match = scan_st.match_flag;
      st.frames_done = scan_st.frame_counter;
      return st;
   endfunction

   function automatic cfg_type make_cfg(bit en, logic [7:0] lyc, logic [3:0] mask,
                                        bit color, bit hdma);
      cfg_type c;
      c.lcd_enable = en;
      c.lyc_value = lyc;
      c.stat_irq_mask = mask;
      c.color_mode = color;
      c.hdma_hblank_mode = hdma;
      return c;
   endfunction

   function automatic stim_row_type setup_row(cfg_type c);
      stim_row_type r;
      r = '{kind: ROW_SETUP, cfg: c, ev: '0, has_lit: 1'b0, lit: '0};
      return r;
   endfunction

   function automatic stim_row_type event_row(logic [1:0] act, logic [15:0] src,
                                              logic [15:0] dst, logic [7:0] blocks);
      stim_row_type r;
      r = '{kind: ROW_EVENT, cfg: '0, ev: '0, has_lit: 1'b0, lit: '0};
      r.ev.action = act;
      r.ev.load_source = src;
      r.ev.load_dest = dst;
      r.ev.load_blocks = blocks;
      return r;
   endfunction

   // Event whose status is plain to see: no pulses except render, no block, no frame yet.
   function automatic stim_row_type known_row(logic [1:0] act, logic [7:0] line,
                                              logic [1:0] mode, bit match, bit render);
      stim_row_type r;
      r = event_row(act, 16'h0, 16'h0, 8'h0);
      r.has_lit = 1'b1;
      r.lit.current_line = line;
      r.lit.lcd_mode = mode;
      r.lit.lyc_match = match;
      r.lit.render_request = render;
      return r;
   endfunction

   function automatic req_type random_event();
      req_type ev;
      int      pick;
      pick = $urandom_range(0, 99);
      if (pick < 60)
         ev.action = ACT_LINE_END;
      else if (pick < 75)
         ev.action = ACT_OAM_START;
      else if (pick < 88)
         ev.action = ACT_XFER_START;
      else
         ev.action = ACT_HDMA_LOAD;
      ev.load_source = 16'($urandom_range(0, 65535));
      ev.load_dest = 16'($urandom_range(0, 65535));
      // Mostly short DMA runs, sometimes empty or long ones.
      case ($urandom_range(0, 9))
         0:       ev.load_blocks = 8'd0;
         1:       ev.load_blocks = 8'($urandom_range(9, 255));
         default: ev.load_blocks = 8'($urandom_range(1, 8));
      endcase
      return ev;
   endfunction

   function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
         error_count++;
      end
   endfunction

   function automatic void compare_status(rsp_type want, rsp_type got);
      check_field("current_line", 16'(want.current_line), 16'(got.current_line));
      check_field("lcd_mode", 16'(want.lcd_mode), 16'(got.lcd_mode));
      check_field("lyc_match", 16'(want.lyc_match), 16'(got.lyc_match));
      check_field("vblank_irq", 16'(want.vblank_irq), 16'(got.vblank_irq));
      check_field("stat_irq", 16'(want.stat_irq), 16'(got.stat_irq));
      check_field("render_request", 16'(want.render_request), 16'(got.render_request));
      check_field("block_valid", 16'(want.block_valid), 16'(got.block_valid));
      check_field("block_source", want.block_source, got.block_source);
      check_field("block_dest", want.block_dest, got.block_dest);
      check_field("dma_finished", 16'(want.dma_finished), 16'(got.dma_finished));
      check_field("frames_done", want.frames_done, got.frames_done);
   endfunction

   // Offer one event after a random gap and record its status once it is taken.
   task automatic send_event(req_type ev, bit has_lit, rsp_type lit);
      int      gap;
      rsp_type predicted;
      gap = (send_calm || calm_left > 0) ? 0 : $urandom_range(0, 15);
      if (calm_left > 0)
         calm_left--;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_action <= ev.action;
      req_load_source <= ev.load_source;
      req_load_dest <= ev.load_dest;
      req_load_blocks <= ev.load_blocks;
      do
         @(posedge clock);
      while (req_stall !== 1'b0);
      predicted = advance_scanline(ev);
      status_due.push_back(has_lit ? lit : predicted);
      events_sent++;
   endtask

   // Stop offering and let every outstanding status arrive.
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (status_due.size() != 0)
         @(negedge clock);
   endtask

   // Write all five registers, one per cycle, while the block is idle.
   task automatic load_settings(cfg_type c);
      logic [CSR_INDEX_W-1:0] slot [5];
      logic [CSR_DATA_W-1:0]  value [5];
      slot = '{CSR_LCD_ENABLE, CSR_LYC_VALUE, CSR_STAT_MASK, CSR_COLOR_MODE, CSR_HDMA_HBLANK};
      value = '{CSR_DATA_W'(c.lcd_enable), CSR_DATA_W'(c.lyc_value),
                CSR_DATA_W'(c.stat_irq_mask), CSR_DATA_W'(c.color_mode),
                CSR_DATA_W'(c.hdma_hblank_mode)};
      for (int i = 0; i < 5; i++) begin
         @(negedge clock);
         csr_write <= 1'b1;
         csr_index <= slot[i];
         csr_wdata <= value[i];
      end
      @(negedge clock);
      csr_write <= 1'b0;
      regs = c;
   endtask

   // Long receiver hold-off so that the block fills and pushes back on its input.
   initial begin
      wait (hold_go);
      @(posedge clock);
      hold_rsp = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp = 1'b0;
   end

   // Receiver stall, changed at the falling edge.
   always @(negedge clock) begin
      if (hold_rsp) begin
         rsp_stall <= 1'b1;
      end else if (rsp_wait_left > 0 && rsp_valid === 1'b1) begin
         rsp_stall <= 1'b1;
         rsp_wait_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Cycle limit and status checking at the rising edge.
   always @(posedge clock) begin : status_check
      rsp_type got;
      rsp_type want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end else if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         got.current_line = rsp_current_line;
         got.lcd_mode = rsp_lcd_mode;
         got.lyc_match = rsp_lyc_match;
         got.vblank_irq = rsp_vblank_irq;
         got.stat_irq = rsp_stat_irq;
         got.render_request = rsp_render_request;
         got.block_valid = rsp_block_valid;
         got.block_source = rsp_block_source;
         got.block_dest = rsp_block_dest;
         got.dma_finished = rsp_dma_finished;
         got.frames_done = rsp_frames_done;
         results_seen++;
         if (got.vblank_irq === 1'b1)
            vblanks_seen++;
         if (got.block_valid === 1'b1)
            blocks_seen++;
         rsp_wait_left = rsp_calm ? 0 : $urandom_range(0, 15);
         if (results_seen % 40 == 0)
            rsp_calm = ($urandom_range(0, 2) == 0);
         if (status_due.size() == 0) begin
            $error("status transaction arrived with none outstanding");
            error_count++;
         end else begin
            want = status_due.pop_front();
            compare_status(want, got);
         end
      end
   end

   // Stimulus: directed table first, then random phases under changing settings.
   initial begin : stimulus
      stim_row_type directed[$];
      stim_row_type row;
      cfg_type      pick;
      int           phase;
      int           live_items;
      int           phase_len;

      directed = '{
         known_row(ACT_OAM_START, 8'd0, MODE_OAM, 1'b1, 1'b0),
         known_row(ACT_XFER_START, 8'd0, MODE_XFER, 1'b1, 1'b1),
         known_row(ACT_LINE_END, 8'd1, MODE_HBLANK, 1'b0, 1'b0),
         setup_row(make_cfg(1'b1, 8'd2, 4'hf, 1'b1, 1'b1)),
         // Compare value changed above; match must wait for the next line end.
         event_row(ACT_HDMA_LOAD, 16'hffff, 16'hffff, 8'd2),
         event_row(ACT_OAM_START, 16'h0, 16'h0, 8'd0),
         event_row(ACT_XFER_START, 16'hffff, 16'hffff, 8'hff),
         event_row(ACT_LINE_END, 16'h0, 16'h0, 8'd0),
         // Second block wraps both addresses.
         event_row(ACT_LINE_END, 16'h0, 16'h0, 8'd0),
         event_row(ACT_LINE_END, 16'h0, 16'h0, 8'd0),
         // Zero block count stores the run but leaves DMA idle.
         event_row(ACT_HDMA_LOAD, 16'h1234, 16'h5678, 8'd0),
         event_row(ACT_LINE_END, 16'h0, 16'h0, 8'd0),
         event_row(ACT_HDMA_LOAD, 16'h0000, 16'h0000, 8'd255),
         event_row(ACT_LINE_END, 16'h0, 16'h0, 8'd0),
         // Reload while a run is active.
         event_row(ACT_HDMA_LOAD, 16'ha5a0, 16'h3c3f, 8'd1),
         event_row(ACT_LINE_END, 16'h0, 16'h0, 8'd0),
         // Display off: nothing moves.
         setup_row(make_cfg(1'b0, 8'd255, 4'h0, 1'b0, 1'b0)),
         known_row(ACT_LINE_END, 8'd7, MODE_HBLANK, 1'b0, 1'b0),
         known_row(ACT_HDMA_LOAD, 8'd7, MODE_HBLANK, 1'b0, 1'b0),
         known_row(ACT_OAM_START, 8'd7, MODE_HBLANK, 1'b0, 1'b0),
         known_row(ACT_XFER_START, 8'd7, MODE_HBLANK, 1'b0, 1'b0),
         setup_row(make_cfg(1'b1, 8'd0, 4'h0, 1'b1, 1'b1)),
         event_row(ACT_LINE_END, 16'h0, 16'h0, 8'd0),
         event_row(ACT_LINE_END, 16'h0, 16'h0, 8'd0)
      };
      directed[18].ev.load_source = 16'h5a5a;
      directed[18].ev.load_dest = 16'hc3c3;
      directed[18].ev.load_blocks = 8'd9;

      scan_st = '0;
      scan_st.mode_bits = MODE_VBLANK;
      scan_st.match_flag = 1'b1;
      scan_st.dma_idle = 1'b1;
      regs = make_cfg(1'b1, 8'd0, 4'h0, 1'b0, 1'b0);

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed[i]) begin
         row = directed[i];
         if (row.kind == ROW_SETUP) begin
            wait_idle();
            load_settings(row.cfg);
         end else begin
            send_event(row.ev, row.has_lit, row.lit);
         end
      end

      live_items = 0;
      phase = 0;
      while (live_items < RANDOM_ITEMS) begin
         wait_idle();
         case (phase)
            0: pick = make_cfg(1'b1, 8'd0, 4'hf, 1'b1, 1'b1);
            1: pick = make_cfg(1'b1, 8'd255, 4'h0, 1'b0, 1'b0);
            2: pick = make_cfg(1'b0, 8'd144, 4'hf, 1'b1, 1'b1);
            3: pick = make_cfg(1'b1, 8'd10, 4'h5, 1'b1, 1'b1);
            default: pick = make_cfg($urandom_range(0, 5) != 0,
                                     ($urandom_range(0, 3) == 0) ?
                                        8'($urandom_range(0, 255)) :
                                        8'($urandom_range(0, 153)),
                                     4'($urandom_range(0, 15)),
                                     $urandom_range(0, 3) != 0,
                                     $urandom_range(0, 3) != 0);
         endcase
         load_settings(pick);
         phase_len = pick.lcd_enable ? 200 : 40;
         for (int n = 0; n < phase_len; n++) begin
            if (n % 50 == 0)
               send_calm = ($urandom_range(0, 3) == 0);
            if (phase == 3 && n == 60) begin
               hold_go = 1'b1;
               calm_left = 40;
            end
            send_event(random_event(), 1'b0, '0);
            if (pick.lcd_enable)
               live_items++;
         end
         phase++;
      end

      wait_idle();
      repeat (8) @(posedge clock);
      $display("Ran %0d events in %0d setting phases; %0d statuses checked.",
               events_sent, phase, results_seen);
      $display("Saw %0d vertical blanks, %0d DMA blocks, frame count %0d.",
               vblanks_seen, blocks_seen, scan_st.frame_counter);
      if (error_count == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

endmodule

[filelist.f]
design/lcdsc_pkg.sv
design/lcdsc_step.sv
design/lcd_scanline_status_controller.sv
design/lcdsc_checker.sv
dv/tb_top.sv
